// ===== hdl/gdg_pkg.sv =====
// ----------------------------------------------------------------------------
// gdg_pkg
// Shared types and constants of the gapped delta-gamma match counter.
// ----------------------------------------------------------------------------
package gdg_pkg;

  localparam int MaxSpanDef  = 64;
  localparam int MaxElemsDef = 8;
  localparam int MaxGammaDef = 7;

  localparam int CntW   = 32;
  localparam int TotW   = 48;
  localparam int SymW   = 8;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] CFG_LETTERS   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_GAP_MIN   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GAP_MAX   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GAP_COUNT = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DELTA     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_GAMMA     = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_MIN_LEN   = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LEN   = 3'd7;

  typedef struct packed {
    logic [63:0] letters;
    logic [27:0] gap_min;
    logic [27:0] gap_max;
    logic [2:0]  gap_count;
    logic [7:0]  delta;
    logic [2:0]  gamma;
    logic [6:0]  min_len;
    logic [6:0]  max_len;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SYM_RD,
    ST_SYM_CHK,
    ST_B_RD,
    ST_B_ACC,
    ST_ROW_WR,
    ST_SUM_RD,
    ST_SUM_LVL,
    ST_FIN
  } state_e;

  function automatic logic [CntW-1:0] sat_add32(logic [CntW-1:0] a, logic [CntW-1:0] b);
    logic [CntW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CntW] ? {CntW{1'b1}} : s[CntW-1:0];
  endfunction

endpackage

// ===== hdl/gapped_delta_gamma_match_counter_unit.sv =====
// ----------------------------------------------------------------------------
// gapped_delta_gamma_match_counter_unit
// Counts gapped delta-gamma pattern occurrences ending at each symbol.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one symbol per word in tdata, tuser is the restart flag
//   that clears the window and the running total before this symbol.
//   m_axis returns one word per symbol: occurrences ending there and the
//   saturating running total of the sequence.
//   cfg writes the pattern registers by index; write only while idle.
// Throughput:
//   one symbol at a time; the work per item depends on the span
//   m = min(max_len, fill), the e pattern elements, the gap widths w and
//   gamma, and is set by the single read port of the path-count scratch
//   memory (one row word per access).
// Reset clears the window pointer, fill level, total and the output slot;
// memories hold no reset value and are always written before being read.
// A finished word waits in the output register while the next symbol is
// already taken; a stalled receiver holds the result and later items wait.
// ----------------------------------------------------------------------------
module gapped_delta_gamma_match_counter_unit #(
  parameter int MAX_SPAN  = gdg_pkg::MaxSpanDef,
  parameter int MAX_ELEMS = gdg_pkg::MaxElemsDef,
  parameter int MAX_GAMMA = gdg_pkg::MaxGammaDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // symbol
  input  logic                           s_axis_tuser,  // restart
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [79:0]                    m_axis_tdata,  // ending_count, running_total
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gdg_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [gdg_pkg::CfgDataW-1:0]   cfg_data_i
);

  gdg_pkg::cfg_t cfg_q;
  logic [gdg_pkg::CntW-1:0] count;
  logic [gdg_pkg::TotW-1:0] total;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.letters   <= '0;
      cfg_q.gap_min   <= '0;
      cfg_q.gap_max   <= '0;
      cfg_q.gap_count <= 3'd1;
      cfg_q.delta     <= '0;
      cfg_q.gamma     <= '0;
      cfg_q.min_len   <= 7'd1;
      cfg_q.max_len   <= 7'd64;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gdg_pkg::CFG_LETTERS:   cfg_q.letters   <= cfg_data_i;
        gdg_pkg::CFG_GAP_MIN:   cfg_q.gap_min   <= cfg_data_i[27:0];
        gdg_pkg::CFG_GAP_MAX:   cfg_q.gap_max   <= cfg_data_i[27:0];
        gdg_pkg::CFG_GAP_COUNT: cfg_q.gap_count <= cfg_data_i[2:0];
        gdg_pkg::CFG_DELTA:     cfg_q.delta     <= cfg_data_i[7:0];
        gdg_pkg::CFG_GAMMA:     cfg_q.gamma     <= cfg_data_i[2:0];
        gdg_pkg::CFG_MIN_LEN:   cfg_q.min_len   <= cfg_data_i[6:0];
        gdg_pkg::CFG_MAX_LEN:   cfg_q.max_len   <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  gdg_ctrl #(
    .MAX_SPAN  (MAX_SPAN),
    .MAX_ELEMS (MAX_ELEMS),
    .MAX_GAMMA (MAX_GAMMA)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_symbol_i  (s_axis_tdata),
    .s_restart_i (s_axis_tuser),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_count_o   (count),
    .m_total_o   (total)
  );

  assign m_axis_tdata = {total, count};

endmodule

// ===== hdl/gdg_ram.sv =====
// ----------------------------------------------------------------------------
// gdg_ram
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module gdg_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/gdg_ctrl.sv =====
// ----------------------------------------------------------------------------
// gdg_ctrl
// Sequencer for the path-count recurrence over the symbol window and scratch.
// ----------------------------------------------------------------------------
module gdg_ctrl #(
  parameter int MAX_SPAN  = gdg_pkg::MaxSpanDef,
  parameter int MAX_ELEMS = gdg_pkg::MaxElemsDef,
  parameter int MAX_GAMMA = gdg_pkg::MaxGammaDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gdg_pkg::cfg_t              cfg_i,
  input  logic                       s_valid_i,
  output logic                       s_ready_o,
  input  logic [gdg_pkg::SymW-1:0]   s_symbol_i,
  input  logic                       s_restart_i,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output logic [gdg_pkg::CntW-1:0]   m_count_o,
  output logic [gdg_pkg::TotW-1:0]   m_total_o
);

  localparam int SpanW  = $clog2(MAX_SPAN);
  localparam int FillW  = $clog2(MAX_SPAN + 1);
  localparam int ElemW  = $clog2(MAX_ELEMS);
  localparam int Levels = MAX_GAMMA + 1;
  localparam int LvlW   = (MAX_GAMMA > 0) ? $clog2(MAX_GAMMA + 1) : 1;
  localparam int CmpW   = FillW + 5;
  localparam int CntW   = gdg_pkg::CntW;
  localparam int TotW   = gdg_pkg::TotW;
  localparam int WordW  = Levels * CntW;
  localparam int ScrD   = 2 ** (ElemW + SpanW);

  gdg_pkg::state_e state_q, state_d;

  logic [SpanW-1:0] head_q, head_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [TotW-1:0]  total_q, total_d;
  logic [7:0]       sym_q, sym_d;
  logic [FillW-1:0] maxl_q, maxl_d;
  logic [ElemW-1:0] last_q, last_d;
  logic [LvlW-1:0]  gm_q, gm_d;
  logic [ElemW-1:0] e_q, e_d;
  logic [SpanW-1:0] a_q, a_d;
  logic [3:0]       g_q, g_d;
  logic [LvlW-1:0]  de_q, de_d;
  logic [LvlW-1:0]  lvl_q, lvl_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0] acc_q, acc_d;
  logic             mv_q, mv_d;
  logic [CntW-1:0]  mcnt_q, mcnt_d;
  logic [TotW-1:0]  mtot_q, mtot_d;

  // memory ports
  logic             win_we;
  logic [SpanW-1:0] win_waddr, win_raddr;
  logic [7:0]       win_rdata;
  logic             scr_we;
  logic [ElemW+SpanW-1:0] scr_waddr, scr_raddr;
  logic [WordW-1:0] scr_wdata, scr_rdata;

  gdg_ram #(.Width(8), .Depth(MAX_SPAN)) u_win (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (win_waddr),
    .wdata_i (s_symbol_i),
    .raddr_i (win_raddr),
    .rdata_o (win_rdata)
  );

  gdg_ram #(.Width(WordW), .Depth(ScrD)) u_scr (
    .clk_i   (clk_i),
    .we_i    (scr_we),
    .waddr_i (scr_waddr),
    .wdata_i (scr_wdata),
    .raddr_i (scr_raddr),
    .rdata_o (scr_rdata)
  );

  // helpers
  logic             accept;
  logic [2:0]       e3;
  logic [7:0]       letter_e, letter_last, de8, d0_8;
  logic [3:0]       gmin, gmax;
  logic [SpanW-1:0] b_age;
  logic [FillW-1:0] a_ext, a_next;
  logic             a_end;
  logic [CmpW-1:0]  a_cmp, g_cmp, min_cmp;
  logic [8:0]       maxlen9, fill9;
  logic [WordW-1:0] init_word;
  logic             out_free;

  assign accept    = s_valid_i && s_ready_o;
  assign s_ready_o = (state_q == gdg_pkg::ST_IDLE);
  assign out_free  = !mv_q || m_ready_i;

  assign e3          = 3'(8'(e_q));
  assign letter_e    = cfg_i.letters[{e3, 3'b000} +: 8];
  assign letter_last = cfg_i.letters[{3'(8'(last_q)), 3'b000} +: 8];
  assign gmin        = 4'(cfg_i.gap_min >> {e3, 2'b00});
  assign gmax        = 4'(cfg_i.gap_max >> {e3, 2'b00});
  assign de8         = (win_rdata >= letter_e) ? win_rdata - letter_e : letter_e - win_rdata;
  assign d0_8        = (sym_q >= letter_last) ? sym_q - letter_last : letter_last - sym_q;

  assign a_ext   = FillW'(a_q);
  assign a_next  = a_ext + FillW'(1);
  assign a_end   = (a_next == maxl_q);
  assign a_cmp   = CmpW'(a_q);
  assign g_cmp   = CmpW'(g_q) + CmpW'(1);
  assign min_cmp = CmpW'(cfg_i.min_len);
  assign b_age   = a_q - SpanW'(1) - SpanW'(g_q);

  // window address of age a, modulo the span
  always_comb begin
    if (head_q >= a_q) begin
      win_raddr = head_q - a_q;
    end else begin
      win_raddr = SpanW'(FillW'(head_q) + FillW'(MAX_SPAN) - a_ext);
    end
  end

  always_comb begin
    init_word = '0;
    if (a_q == '0 && d0_8 <= cfg_i.delta && d0_8 <= 8'(gm_q)) begin
      for (int j = 0; j < Levels; j++) begin
        if (LvlW'(j) == LvlW'(d0_8)) begin
          init_word[j*CntW +: CntW] = CntW'(1);
        end
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gdg_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (maxl_d == '0) ? gdg_pkg::ST_FIN : gdg_pkg::ST_INIT;
        end
      end
      gdg_pkg::ST_INIT: begin
        if (a_end) begin
          state_d = (last_q == '0) ? gdg_pkg::ST_SUM_RD : gdg_pkg::ST_SYM_RD;
        end
      end
      gdg_pkg::ST_SYM_RD: state_d = gdg_pkg::ST_SYM_CHK;
      gdg_pkg::ST_SYM_CHK: begin
        if (a_q != '0 && de8 <= cfg_i.delta && de8 <= 8'(gm_q) && gmin <= gmax &&
            CmpW'(gmin) < a_cmp) begin
          state_d = gdg_pkg::ST_B_RD;
        end else begin
          state_d = gdg_pkg::ST_ROW_WR;
        end
      end
      gdg_pkg::ST_B_RD: state_d = gdg_pkg::ST_B_ACC;
      gdg_pkg::ST_B_ACC: begin
        state_d = (g_q == gmax || g_cmp >= a_cmp) ? gdg_pkg::ST_ROW_WR : gdg_pkg::ST_B_RD;
      end
      gdg_pkg::ST_ROW_WR: begin
        if (a_end && e_q == '0) begin
          state_d = gdg_pkg::ST_SUM_RD;
        end else begin
          state_d = gdg_pkg::ST_SYM_RD;
        end
      end
      gdg_pkg::ST_SUM_RD: state_d = gdg_pkg::ST_SUM_LVL;
      gdg_pkg::ST_SUM_LVL: begin
        if (CmpW'(a_next) < min_cmp || lvl_q == gm_q) begin
          state_d = a_end ? gdg_pkg::ST_FIN : gdg_pkg::ST_SUM_RD;
        end
      end
      gdg_pkg::ST_FIN: begin
        if (out_free) begin
          state_d = gdg_pkg::ST_IDLE;
        end
      end
      default: state_d = gdg_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    head_d  = head_q;
    fill_d  = fill_q;
    total_d = total_q;
    sym_d   = sym_q;
    maxl_d  = maxl_q;
    last_d  = last_q;
    gm_d    = gm_q;
    e_d     = e_q;
    a_d     = a_q;
    g_d     = g_q;
    de_d    = de_q;
    lvl_d   = lvl_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    mcnt_d  = mcnt_q;
    mtot_d  = mtot_q;
    mv_d    = mv_q && !m_ready_i;
    win_we    = 1'b0;
    win_waddr = head_q;
    scr_we    = 1'b0;
    scr_waddr = {e_q, a_q};
    scr_wdata = acc_q;
    scr_raddr = {ElemW'(0), a_q};
    maxlen9   = 9'(cfg_i.max_len);
    fill9     = '0;

    case (state_q)
      gdg_pkg::ST_IDLE: begin
        if (accept) begin
          if (s_restart_i) begin
            head_d  = SpanW'(1);
            fill_d  = FillW'(1);
            total_d = '0;
          end else begin
            head_d = (head_q == SpanW'(MAX_SPAN - 1)) ? '0 : head_q + SpanW'(1);
            fill_d = (fill_q == FillW'(MAX_SPAN)) ? fill_q : fill_q + FillW'(1);
          end
          win_we    = 1'b1;
          win_waddr = head_d;
          sym_d     = s_symbol_i;
          if (maxlen9 > 9'(MAX_SPAN)) begin
            maxlen9 = 9'(MAX_SPAN);
          end
          fill9  = 9'(fill_d);
          maxl_d = FillW'((maxlen9 < fill9) ? maxlen9 : fill9);
          if (32'(cfg_i.gap_count) + 1 > MAX_ELEMS) begin
            last_d = ElemW'(MAX_ELEMS - 1);
          end else begin
            last_d = ElemW'(cfg_i.gap_count);
          end
          gm_d  = (32'(cfg_i.gamma) > MAX_GAMMA) ? LvlW'(MAX_GAMMA) : LvlW'(cfg_i.gamma);
          a_d   = '0;
          cnt_d = '0;
        end
      end
      gdg_pkg::ST_INIT: begin
        scr_we    = 1'b1;
        scr_waddr = {last_q, a_q};
        scr_wdata = init_word;
        if (a_end) begin
          a_d = '0;
          e_d = last_q - ElemW'(1);
        end else begin
          a_d = a_q + SpanW'(1);
        end
      end
      gdg_pkg::ST_SYM_CHK: begin
        acc_d = '0;
        de_d  = LvlW'(de8);
        g_d   = gmin;
      end
      gdg_pkg::ST_B_RD: begin
        scr_raddr = {e_q + ElemW'(1), b_age};
      end
      gdg_pkg::ST_B_ACC: begin
        for (int j = 0; j < Levels; j++) begin
          if (LvlW'(j) >= de_q && LvlW'(j) <= gm_q) begin
            acc_d[j*CntW +: CntW] = gdg_pkg::sat_add32(acc_q[j*CntW +: CntW],
                scr_rdata[(LvlW'(j) - de_q)*CntW +: CntW]);
          end
        end
        g_d = g_q + 4'd1;
      end
      gdg_pkg::ST_ROW_WR: begin
        scr_we = 1'b1;
        if (a_end) begin
          a_d = '0;
          if (e_q != '0) begin
            e_d = e_q - ElemW'(1);
          end
        end else begin
          a_d = a_q + SpanW'(1);
        end
        lvl_d = '0;
      end
      gdg_pkg::ST_SUM_RD: begin
        lvl_d = '0;
      end
      gdg_pkg::ST_SUM_LVL: begin
        if (CmpW'(a_next) >= min_cmp) begin
          cnt_d = gdg_pkg::sat_add32(cnt_q, scr_rdata[lvl_q*CntW +: CntW]);
        end
        if (CmpW'(a_next) < min_cmp || lvl_q == gm_q) begin
          a_d = a_q + SpanW'(1);
        end else begin
          lvl_d = lvl_q + LvlW'(1);
        end
      end
      gdg_pkg::ST_FIN: begin
        if (out_free) begin
          if (({1'b0, total_q} + (TotW + 1)'(cnt_q)) > (TotW + 1)'({TotW{1'b1}})) begin
            total_d = {TotW{1'b1}};
          end else begin
            total_d = total_q + TotW'(cnt_q);
          end
          mv_d   = 1'b1;
          mcnt_d = cnt_q;
          mtot_d = total_d;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gdg_pkg::ST_IDLE;
      head_q  <= '0;
      fill_q  <= '0;
      total_q <= '0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      fill_q  <= fill_d;
      total_q <= total_d;
      mv_q    <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q  <= sym_d;
    maxl_q <= maxl_d;
    last_q <= last_d;
    gm_q   <= gm_d;
    e_q    <= e_d;
    a_q    <= a_d;
    g_q    <= g_d;
    de_q   <= de_d;
    lvl_q  <= lvl_d;
    cnt_q  <= cnt_d;
    acc_q  <= acc_d;
    mcnt_q <= mcnt_d;
    mtot_q <= mtot_d;
  end

  assign m_valid_o = mv_q;
  assign m_count_o = mcnt_q;
  assign m_total_o = mtot_q;

endmodule

// ===== tb/gdg_match_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdg_match_checker
// Watches the symbol, result and register channels of the match counter,
// predicts each result word from its own copy of the pattern registers and
// the symbol window, and compares field by field in arrival order.
// ----------------------------------------------------------------------------
module gdg_match_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          sym_valid_i,
  input  logic                          sym_ready_i,
  input  logic [7:0]                    sym_data_i,     // symbol
  input  logic                          sym_restart_i,  // restart
  input  logic                          res_valid_i,
  input  logic                          res_ready_i,
  input  logic [79:0]                   res_data_i,     // ending_count, running_total
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [gdg_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gdg_pkg::CfgDataW-1:0]  cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            results_o
);
  import gdg_pkg::*;

  localparam int Span  = MaxSpanDef;
  localparam int Elems = MaxElemsDef;
  localparam int Gam   = MaxGammaDef;

  // ending count sits in the low bits of the word
  typedef struct packed {
    logic [47:0] total;
    logic [31:0] ending;
  } match_word_t;

  cfg_t        pat_q;
  logic [7:0]  window_q [Span];
  int          head_q;
  int          fill_q;
  logic [47:0] total_q;
  logic [31:0] paths [Elems][Span][Gam+1];
  match_word_t expected_words [$];

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic int dist8(logic [7:0] a, logic [7:0] b);
    return (a >= b) ? int'(a - b) : int'(b - a);
  endfunction

  // count occurrences ending at the new symbol, walking the pattern backward
  task automatic count_matches(input logic [7:0] sym, input logic restart,
                               output match_word_t word);
    int last, gm, maxl, e, a, b, d, de, gmin, gmax, lim;
    logic [31:0] cnt;
    logic [48:0] t;
    if (restart) begin
      foreach (window_q[i]) window_q[i] = '0;
      head_q  = 0;
      fill_q  = 0;
      total_q = '0;
    end
    head_q = (head_q + 1) % Span;
    window_q[head_q] = sym;
    if (fill_q < Span) fill_q++;
    last = int'(pat_q.gap_count);
    if (last > Elems - 1) last = Elems - 1;
    gm   = (int'(pat_q.gamma) > Gam) ? Gam : int'(pat_q.gamma);
    maxl = (int'(pat_q.max_len) > Span) ? Span : int'(pat_q.max_len);
    if (maxl > fill_q) maxl = fill_q;
    foreach (paths[i, j, k]) paths[i][j][k] = '0;
    d = dist8(sym, pat_q.letters[8*last +: 8]);
    if (d <= int'(pat_q.delta) && d <= gm) paths[last][0][d] = 1;
    for (e = last - 1; e >= 0; e--) begin
      gmin = int'(pat_q.gap_min[4*e +: 4]);
      gmax = int'(pat_q.gap_max[4*e +: 4]);
      for (a = 1; a < maxl; a++) begin
        de = dist8(window_q[(head_q + Span - a) % Span], pat_q.letters[8*e +: 8]);
        if (de > int'(pat_q.delta) || de > gm) continue;
        for (b = 0; b < a; b++) begin
          if (a - b - 1 < gmin || a - b - 1 > gmax) continue;
          lim = gm - de;
          for (d = 0; d <= lim; d++)
            paths[e][a][d + de] = add_sat(paths[e][a][d + de], paths[e+1][b][d]);
        end
      end
    end
    cnt = '0;
    for (a = 0; a < maxl; a++) begin
      if (a + 1 < int'(pat_q.min_len)) continue;
      for (d = 0; d <= gm; d++) cnt = add_sat(cnt, paths[0][a][d]);
    end
    t = {1'b0, total_q} + {17'b0, cnt};
    total_q = t[48] ? 48'hFFFF_FFFF_FFFF : t[47:0];
    word.ending = cnt;
    word.total  = total_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    match_word_t exp_w, got_w;
    if (!rst_ni) begin
      pat_q = '0;
      pat_q.gap_count = 3'd1;
      pat_q.min_len   = 7'd1;
      pat_q.max_len   = 7'd64;
      foreach (window_q[i]) window_q[i] = '0;
      head_q = 0;
      fill_q = 0;
      total_q = '0;
      expected_words.delete();
      fail_count_o = 0;
      results_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_LETTERS:   pat_q.letters   = cfg_data_i;
          CFG_GAP_MIN:   pat_q.gap_min   = cfg_data_i[27:0];
          CFG_GAP_MAX:   pat_q.gap_max   = cfg_data_i[27:0];
          CFG_GAP_COUNT: pat_q.gap_count = cfg_data_i[2:0];
          CFG_DELTA:     pat_q.delta     = cfg_data_i[7:0];
          CFG_GAMMA:     pat_q.gamma     = cfg_data_i[2:0];
          CFG_MIN_LEN:   pat_q.min_len   = cfg_data_i[6:0];
          CFG_MAX_LEN:   pat_q.max_len   = cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (res_valid_i && res_ready_i) begin
        got_w = res_data_i;
        results_o++;
        if (expected_words.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected result word: count %0d total %0d",
                     got_w.ending, got_w.total);
        end else begin
          exp_w = expected_words.pop_front();
          if (got_w.ending !== exp_w.ending || got_w.total !== exp_w.total) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("result %0d mismatch: count exp %0d got %0d, total exp %0d got %0d",
                       results_o, exp_w.ending, got_w.ending, exp_w.total, got_w.total);
          end
        end
      end
      if (sym_valid_i && sym_ready_i) begin
        count_matches(sym_data_i, sym_restart_i, exp_w);
        expected_words.push_back(exp_w);
      end
    end
    pending_o = expected_words.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives symbol streams and pattern register settings into the match
// counter with random idling on both sides and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
  import gdg_pkg::*;

  localparam longint CycleLimit = 40_000_000;

  logic        clk;
  logic        rst_n;
  logic        sym_valid;
  logic        sym_ready;
  logic [7:0]  sym_data;     // symbol
  logic        sym_restart;  // restart
  logic        res_valid;
  logic        res_ready;
  logic [79:0] res_data;     // ending_count, running_total
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  int     fail_count, pending, results;
  longint cycles;
  int     symbols_sent, phases_run;
  int     hold_req;
  bit     quiet;
  logic [63:0] cur_letters;
  int     cur_elems;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  gapped_delta_gamma_match_counter_unit i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (sym_valid),
    .s_axis_tready (sym_ready),
    .s_axis_tdata  (sym_data),
    .s_axis_tuser  (sym_restart),
    .m_axis_tvalid (res_valid),
    .m_axis_tready (res_ready),
    .m_axis_tdata  (res_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  gdg_match_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .sym_valid_i   (sym_valid),
    .sym_ready_i   (sym_ready),
    .sym_data_i    (sym_data),
    .sym_restart_i (sym_restart),
    .res_valid_i   (res_valid),
    .res_ready_i   (res_ready),
    .res_data_i    (res_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .results_o     (results)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
      $display("tb failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 150);
  endfunction

  // receiver: random stalls plus a requested long hold-off
  initial begin : receiver
    int stall;
    res_ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        stall = hold_req;
        hold_req = 0;
      end
      if (stall > 0) begin
        stall--;
        res_ready <= 1'b0;
      end else begin
        stall = idle_len();
        res_ready <= (stall == 0);
      end
    end
  end

  task automatic send_symbol(input logic [7:0] sym, input logic restart);
    int gap;
    bit taken;
    gap = idle_len();
    if (gap > 0) begin
      sym_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sym_valid   <= 1'b1;
    sym_data    <= sym;
    sym_restart <= restart;
    do begin
      @(posedge clk);
      taken = sym_ready;
      @(negedge clk);
    end while (!taken);
    symbols_sent++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(posedge clk);
      taken = cfg_ready;
      @(negedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    if (idx == CFG_LETTERS) cur_letters = val;
    if (idx == CFG_GAP_COUNT) cur_elems = int'(val[2:0]) + 1;
  endtask

  task automatic drain();
    sym_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic load_pattern(input logic [63:0] lt, input logic [27:0] gmin,
                              input logic [27:0] gmax, input logic [2:0] gc,
                              input logic [7:0] dl, input logic [2:0] gm,
                              input logic [6:0] mnl, input logic [6:0] mxl);
    drain();
    write_reg(CFG_LETTERS, lt);
    write_reg(CFG_GAP_MIN, {36'b0, gmin});
    write_reg(CFG_GAP_MAX, {36'b0, gmax});
    write_reg(CFG_GAP_COUNT, {61'b0, gc});
    write_reg(CFG_DELTA, {56'b0, dl});
    write_reg(CFG_GAMMA, {61'b0, gm});
    write_reg(CFG_MIN_LEN, {57'b0, mnl});
    write_reg(CFG_MAX_LEN, {57'b0, mxl});
    phases_run++;
  endtask

  // mostly the pattern in order with filler between, some noise
  task automatic send_stream(input int n);
    int e, r, filler;
    logic [7:0] s;
    e = 0;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        s = cur_letters[8*e +: 8] + 8'($urandom_range(0, 4)) - 8'd2;
        e = (e + 1) % cur_elems;
      end else if (r < 85) begin
        filler = $urandom_range(0, cur_elems - 1);
        s = cur_letters[8*filler +: 8];
      end else begin
        s = 8'($urandom);
        e = 0;
      end
      send_symbol(s, $urandom_range(0, 99) < 3);
    end
  endtask

  task automatic random_phase(input bit heavy, input int n);
    logic [63:0] lt;
    logic [27:0] gmin, gmax;
    logic [6:0]  mnl, mxl;
    logic [3:0]  lo, w;
    int r;
    lt = {$urandom, $urandom};
    if ($urandom_range(0, 1)) lt = lt & 64'h0303_0303_0303_0303;
    for (int k = 0; k < 7; k++) begin
      lo = heavy ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 2));
      w  = heavy ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
      gmin[4*k +: 4] = lo;
      gmax[4*k +: 4] = ($urandom_range(0, 9) == 0) ? lo - 4'd1 : lo + w;
    end
    r   = $urandom_range(0, 99);
    mxl = heavy ? 7'($urandom_range(64, 127)) : 7'($urandom_range(1, 12));
    mnl = (r < 10) ? 7'($urandom_range(1, 127)) : 7'($urandom_range(1, 4));
    load_pattern(lt, gmin, gmax, heavy ? 3'd7 : 3'($urandom_range(0, 3)),
                 ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)),
                 3'($urandom), mnl, mxl);
    quiet = ($urandom_range(0, 4) == 0);
    send_stream(n);
  endtask

  initial begin
    cycles = 0;
    symbols_sent = 0;
    phases_run = 0;
    hold_req = 0;
    quiet = 1'b0;
    cur_letters = '0;
    cur_elems = 2;
    rst_n = 1'b0;
    sym_valid = 1'b0;
    sym_data = '0;
    sym_restart = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_LETTERS;
    cfg_data = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset values: letters zero, so zero symbols match two-element runs
    send_symbol(8'd0, 1'b0);
    send_symbol(8'd0, 1'b0);
    send_symbol(8'd255, 1'b0);
    send_symbol(8'd0, 1'b1);
    send_symbol(8'd0, 1'b0);
    // single element, widest delta and gamma, all-ones letters
    load_pattern(64'hFFFF_FFFF_FFFF_FFFF, 28'h0, 28'hFFF_FFFF, 3'd0, 8'd255, 3'd7,
                 7'd1, 7'd127);
    send_symbol(8'd255, 1'b0);
    send_symbol(8'd248, 1'b0);
    send_symbol(8'd0, 1'b0);
    send_symbol(8'd254, 1'b1);
    // eight elements, inverted gap bound on one gap, then inverted lengths
    load_pattern(64'h0706_0504_0302_0100, 28'h000_0F00, 28'hFFF_F0FF, 3'd7, 8'd1, 3'd3,
                 7'd1, 7'd16);
    for (int i = 0; i < 8; i++) send_symbol(8'(i), 1'b0);
    load_pattern(64'h0, 28'h0, 28'h1, 3'd1, 8'd0, 3'd0, 7'd20, 7'd5);
    send_symbol(8'd0, 1'b0);
    send_symbol(8'd0, 1'b0);
    send_symbol(8'd0, 1'b0);

    // long receiver hold-off while symbols keep coming
    load_pattern(64'h0000_0000_0000_0201, 28'h0, 28'h2, 3'd1, 8'd2, 3'd4, 7'd1, 7'd6);
    cur_elems = 2;
    quiet = 1'b1;
    hold_req = 4000;
    send_stream(12);
    quiet = 1'b0;

    for (int p = 0; p < 4; p++) random_phase(1'b1, 4);
    while (symbols_sent < 1170) random_phase(1'b0, $urandom_range(20, 60));

    drain();
    repeat (200) @(negedge clk);
    $display("%0d symbols over %0d pattern settings, %0d result words checked",
             symbols_sent, phases_run, results);
    if (fail_count == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("%0d mismatches, %0d words outstanding", fail_count, pending);
      $display("tb failed");
    end
    $finish;
  end

endmodule
